@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the I2C master bit engine.
// Synthesis builds define SYNTH, which leaves every macro empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge out of reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
// Expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

@@ rtl/i2cmbe_pkg.sv @@
// Types and constants of the I2C master bit engine.
// Used by i2cmbe_seq and i2c_master_bit_engine; depends on nothing.
package i2cmbe_pkg;

	// Command codes on the input beat
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;
	localparam logic [2:0] OP_WACK  = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_TICKS_PER_UNIT = 2'd0;
	localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd1;

	localparam logic [15:0] TICKS_PER_UNIT_RST = 16'd200;
	localparam logic [7:0]  ACK_TIMEOUT_RST    = 8'd250;

	// Sequencer phase codes
	localparam logic [4:0] PH_IDLE    = 5'd0;
	localparam logic [4:0] PH_ST_A    = 5'd1;
	localparam logic [4:0] PH_ST_B    = 5'd2;
	localparam logic [4:0] PH_ST_C    = 5'd3;
	localparam logic [4:0] PH_SP_A    = 5'd4;
	localparam logic [4:0] PH_SP_B    = 5'd5;
	localparam logic [4:0] PH_SP_C    = 5'd6;
	localparam logic [4:0] PH_WA_A    = 5'd7;
	localparam logic [4:0] PH_WA_B    = 5'd8;
	localparam logic [4:0] PH_WA_POLL = 5'd9;
	localparam logic [4:0] PH_WR_BIT  = 5'd10;
	localparam logic [4:0] PH_WR_HI   = 5'd11;
	localparam logic [4:0] PH_WR_LO   = 5'd12;
	localparam logic [4:0] PH_RD_LO   = 5'd13;
	localparam logic [4:0] PH_RD_HI   = 5'd14;
	localparam logic [4:0] PH_AK_A    = 5'd15;
	localparam logic [4:0] PH_AK_B    = 5'd16;
	localparam logic [4:0] PH_AK_C    = 5'd17;

	typedef struct packed {
		logic [15:0] ticks_per_unit;
		logic [7:0]  ack_timeout;
	} cfg_t;

	// Last member sits in the lowest bits
	typedef struct packed {
		logic       ack_error;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       busy_res;
		logic       sda_enable;
		logic       sda_drive;
		logic       scl_level;
	} res_t;

endpackage

@@ rtl/i2c_master_bit_engine.sv @@
// I2C master bit engine: top level with stream ports, config registers and result register.
// Depends on i2cmbe_pkg, i2cmbe_seq and assert_macros.svh.
//
// Usage:
//   Each input beat on s_* is one tick of bus timing. It may carry a command in s_tuser
//   (none, start, stop, write byte, read byte, wait for ack) and always carries the sampled
//   SDA pin level. Commands that arrive while a sequence is running are dropped.
//   Every input beat yields exactly one result beat on m_* with the SCL/SDA drive after
//   that tick, busy and done flags, the last received byte and the ack error flag.
//   The result beat comes in the cycle after its input beat; a beat is taken every cycle.
//   The result register decouples the sides: a new beat is taken in the cycle the
//   pending result is drained, so a stalled receiver stalls the input only while the
//   result register is full and m_tready is low.
//   Config writes (cfg_index 0: ticks_per_unit, 1: ack_timeout) are always ready and
//   belong to idle periods; other indexes are ignored. A delay unit lasts
//   ticks_per_unit ticks (zero acts as one).
//   Reset: phase idle, SCL and SDA driven high, flags and received byte cleared,
//   ticks_per_unit 200 and ack_timeout 250; no result is pending.
`include "assert_macros.svh"

module i2c_master_bit_engine
	import i2cmbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Tick beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] send_ack, [9] sda_level, rest zero
	input  logic [2:0]  s_tuser,   // [2:0] operation
	// Result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] scl_level, [1] sda_drive, [2] sda_enable,
	                               // [3] busy_res, [4] done_res, [12:5] rx_byte,
	                               // [13] ack_error, rest zero
	// Config writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t  cfg_q;
	res_t  res;
	res_t  res_q;
	logic  m_valid_q;
	logic  accept;

	// Take a beat whenever the result register is empty or draining
	assign s_tready  = !m_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_unit <= TICKS_PER_UNIT_RST;
			cfg_q.ack_timeout    <= ACK_TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TICKS_PER_UNIT: cfg_q.ticks_per_unit <= cfg_data;
				REG_ACK_TIMEOUT:    cfg_q.ack_timeout    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	i2cmbe_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.operation (s_tuser),
		.tx_byte   (s_tdata[7:0]),
		.send_ack  (s_tdata[8]),
		.sda_level (s_tdata[9]),
		.cfg       (cfg_q),
		.res       (res)
	);

	// Result register: load on accept, drop when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, res_q};

	// A finished command never reports busy in the same beat
	`ASSERT_NEVER(a_done_not_busy, clk, arst_n, m_tvalid && res_q.done_res && res_q.busy_res)
	// Every accepted tick leaves a result pending on the next cycle
	`ASSERT_AT(a_beat_has_result, clk, arst_n, accept |=> m_valid_q)

endmodule

@@ rtl/i2cmbe_seq.sv @@
// Bus sequencer of the I2C master bit engine: phase state and one-tick update.
// Depends on i2cmbe_pkg.
module i2cmbe_seq
	import i2cmbe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [2:0] operation,
	input  logic [7:0] tx_byte,
	input  logic       send_ack,
	input  logic       sda_level,
	input  cfg_t       cfg,
	output res_t       res
);

	logic [4:0]  phase_q,   phase_d;
	logic [15:0] tick_q,    tick_d;
	logic [2:0]  unit_q,    unit_d;
	logic [3:0]  bit_q,     bit_d;
	logic [7:0]  shift_q,   shift_d;
	logic [7:0]  tmo_q,     tmo_d;
	logic        ackc_q,    ackc_d;
	logic        scl_q,     scl_d;
	logic        sda_q,     sda_d;
	logic        sda_en_q,  sda_en_d;
	logic        err_q,     err_d;
	logic [7:0]  rx_q,      rx_d;
	logic        done_d;
	logic [15:0] unit_len;

	assign unit_len = (cfg.ticks_per_unit == '0) ? 16'd1 : cfg.ticks_per_unit;

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		unit_d   = unit_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		tmo_d    = tmo_q;
		ackc_d   = ackc_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		sda_en_d = sda_en_q;
		err_d    = err_q;
		rx_d     = rx_q;
		done_d   = 1'b0;

		// Take a new command only when idle
		if (phase_d == PH_IDLE && operation >= OP_START && operation <= OP_WACK) begin
			unit_d = '0;
			tick_d = '0;
			bit_d  = '0;
			case (operation)
				OP_START: phase_d = PH_ST_A;
				OP_STOP:  phase_d = PH_SP_A;
				OP_WRITE: begin
					phase_d = PH_WR_BIT;
					shift_d = tx_byte;
				end
				OP_READ: begin
					phase_d = PH_RD_LO;
					shift_d = '0;
					ackc_d  = send_ack;
				end
				default: begin
					phase_d = PH_WA_A;
					tmo_d   = '0;
					err_d   = 1'b0;
				end
			endcase
		end

		if (phase_d == PH_WA_POLL) begin
			if (!sda_level) begin
				scl_d   = 1'b0;
				phase_d = PH_IDLE;
				unit_d  = '0;
				tick_d  = '0;
				done_d  = 1'b1;
			end else if (tmo_d >= cfg.ack_timeout) begin
				err_d   = 1'b1;
				phase_d = PH_SP_A;
				unit_d  = '0;
				tick_d  = '0;
			end else begin
				tmo_d = tmo_d + 8'd1;
			end
		end else if (phase_d != PH_IDLE) begin
			// First tick of a step: set pins and load the delay
			if (unit_d == '0) begin
				tick_d = '0;
				case (phase_d)
					PH_ST_A: begin
						sda_en_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1; unit_d = 3'd4;
					end
					PH_ST_B: begin
						sda_d = 1'b0; unit_d = 3'd4;
					end
					PH_ST_C: begin
						scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1;
					end
					PH_SP_A: begin
						sda_en_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0; unit_d = 3'd4;
					end
					PH_SP_B: begin
						scl_d = 1'b1; unit_d = 3'd4;
					end
					PH_SP_C: begin
						sda_d = 1'b1; phase_d = PH_IDLE; done_d = 1'b1;
					end
					PH_WA_A: begin
						sda_en_d = 1'b0; sda_d = 1'b1; unit_d = 3'd1;
					end
					PH_WA_B: begin
						scl_d = 1'b1; unit_d = 3'd1;
					end
					PH_WR_BIT: begin
						sda_en_d = 1'b1; scl_d = 1'b0;
						sda_d    = shift_d[7];
						shift_d  = {shift_d[6:0], 1'b0};
						unit_d   = 3'd2;
					end
					PH_WR_HI: begin
						scl_d = 1'b1; unit_d = 3'd2;
					end
					PH_WR_LO: begin
						scl_d = 1'b0; unit_d = 3'd2;
					end
					PH_RD_LO: begin
						sda_en_d = 1'b0; scl_d = 1'b0; unit_d = 3'd2;
					end
					PH_RD_HI: begin
						// sample on the first tick of SCL high
						scl_d   = 1'b1;
						shift_d = {shift_d[6:0], sda_level};
						unit_d  = 3'd1;
					end
					PH_AK_A: begin
						scl_d = 1'b0; sda_en_d = 1'b1; sda_d = ~ackc_d; unit_d = 3'd2;
					end
					PH_AK_B: begin
						scl_d = 1'b1; unit_d = 3'd2;
					end
					PH_AK_C: begin
						// drop SCL after the ack bit and finish
						scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1;
					end
					default: begin
						phase_d = PH_IDLE; done_d = 1'b1;
					end
				endcase
			end

			// Count the delay and advance at its end
			if (phase_d != PH_IDLE && unit_d != '0) begin
				tick_d = tick_d + 16'd1;
				if (tick_d >= unit_len) begin
					tick_d = '0;
					unit_d = unit_d - 3'd1;
					if (unit_d == '0) begin
						case (phase_d)
							PH_ST_A:  phase_d = PH_ST_B;
							PH_ST_B:  phase_d = PH_ST_C;
							PH_SP_A:  phase_d = PH_SP_B;
							PH_SP_B:  phase_d = PH_SP_C;
							PH_WA_A:  phase_d = PH_WA_B;
							PH_WA_B:  phase_d = PH_WA_POLL;
							PH_WR_BIT: phase_d = PH_WR_HI;
							PH_WR_HI: phase_d = PH_WR_LO;
							PH_WR_LO: begin
								bit_d = bit_d + 4'd1;
								if (bit_d >= 4'd8) begin
									phase_d = PH_IDLE; done_d = 1'b1;
								end else begin
									phase_d = PH_WR_BIT;
								end
							end
							PH_RD_LO: phase_d = PH_RD_HI;
							PH_RD_HI: begin
								bit_d = bit_d + 4'd1;
								if (bit_d >= 4'd8) begin
									rx_d    = shift_d;
									phase_d = PH_AK_A;
								end else begin
									phase_d = PH_RD_LO;
								end
							end
							PH_AK_A: phase_d = PH_AK_B;
							PH_AK_B: phase_d = PH_AK_C;
							default: begin
								phase_d = PH_IDLE; done_d = 1'b1;
							end
						endcase
					end
				end
			end
		end
	end

	always_comb begin
		res.scl_level  = scl_d;
		res.sda_drive  = sda_d;
		res.sda_enable = sda_en_d;
		res.busy_res   = (phase_d != PH_IDLE);
		res.done_res   = done_d;
		res.rx_byte    = rx_d;
		res.ack_error  = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			unit_q   <= '0;
			bit_q    <= '0;
			shift_q  <= '0;
			tmo_q    <= '0;
			ackc_q   <= 1'b0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			sda_en_q <= 1'b1;
			err_q    <= 1'b0;
			rx_q     <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			unit_q   <= unit_d;
			bit_q    <= bit_d;
			shift_q  <= shift_d;
			tmo_q    <= tmo_d;
			ackc_q   <= ackc_d;
			scl_q    <= scl_d;
			sda_q    <= sda_d;
			sda_en_q <= sda_en_d;
			err_q    <= err_d;
			rx_q     <= rx_d;
		end
	end

endmodule

@@ tb/tb_i2c_master_bit_engine.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the I2C master bit engine: tick beats in, one pin-state beat out.
// Depends on i2cmbe_pkg and the i2c_master_bit_engine RTL; reads no files.
module tb_i2c_master_bit_engine;
	import i2cmbe_pkg::*;

	// Operation codes the block must ignore
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	// How the SDA pin answers while a command runs
	localparam int SDA_LOW        = 0;
	localparam int SDA_HIGH       = 1;
	localparam int SDA_RANDOM     = 2;
	localparam int SDA_SPARSE_LOW = 3;

	// Cycles without any accepted beat before the run is declared hung
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [2:0] op;
		logic [7:0] tx;
		logic       ack;
		logic       sda;
		bit         drain;   // hold this beat until every result is back
	} tick_t;

	// Shadow copy of the sequencer state
	typedef struct {
		logic [4:0]  phase;
		logic [2:0]  cmd;
		logic [16:0] ticks;
		logic [2:0]  units;
		logic [3:0]  bit_idx;
		logic [7:0]  shreg;
		logic [7:0]  polls;
		logic        ack_low;
		logic        scl;
		logic        sda;
		logic        sda_en;
		logic        err;
		logic [7:0]  rx;
		logic        done;
	} bus_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [7:0] tx_byte, [8] send_ack, [9] sda_level, rest zero
	logic [2:0]  s_tuser = '0;   // [2:0] operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [0] scl_level, [1] sda_drive, [2] sda_enable, [3] busy_res,
	                             // [4] done_res, [12:5] rx_byte, [13] ack_error, rest zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	tick_t      tick_q[$];          // beats waiting to be driven
	res_t       pin_results_q[$];   // predicted pin states, oldest first
	bus_state_t lookahead_bus;      // runs ahead at generation time to find idle points
	bus_state_t shadow_bus;         // advanced on each accepted beat
	logic [15:0] tpu_reg = TICKS_PER_UNIT_RST;
	logic [7:0]  ato_reg = ACK_TIMEOUT_RST;
	int          gen_ticks = 0;
	int          ticks_in = 0;
	int          results_out = 0;
	int          errors = 0;
	int          src_idle_pct = 0;
	int          sink_idle_pct = 0;
	int          src_gap = 0;
	int          sink_gap = 0;
	int          stall_cycles = 0;

	i2c_master_bit_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------------
	// Sequencer prediction
	// ---------------------------------------------------------------------------------------
	function automatic bus_state_t bus_reset();
		bus_state_t b;
		b = '{default: '0};
		b.phase = PH_IDLE;
		b.scl = 1'b1;
		b.sda = 1'b1;
		b.sda_en = 1'b1;
		return b;
	endfunction

	function automatic void seq_finish(inout bus_state_t b);
		b.phase = PH_IDLE;
		b.units = '0;
		b.ticks = '0;
		b.done = 1'b1;
	endfunction

	function automatic void seq_hold(inout bus_state_t b, input logic [2:0] n);
		b.units = n;
		b.ticks = '0;
	endfunction

	// First tick of a step: set the pins and load its delay
	function automatic void seq_enter(inout bus_state_t b, input logic sda_in);
		case (b.phase)
			PH_ST_A: begin
				b.sda_en = 1'b1; b.sda = 1'b1; b.scl = 1'b1; seq_hold(b, 3'd4);
			end
			PH_ST_B: begin
				b.sda = 1'b0; seq_hold(b, 3'd4);
			end
			PH_ST_C: begin
				b.scl = 1'b0; seq_finish(b);
			end
			PH_SP_A: begin
				b.sda_en = 1'b1; b.scl = 1'b0; b.sda = 1'b0; seq_hold(b, 3'd4);
			end
			PH_SP_B: begin
				b.scl = 1'b1; seq_hold(b, 3'd4);
			end
			PH_SP_C: begin
				b.sda = 1'b1; seq_finish(b);
			end
			PH_WA_A: begin
				b.sda_en = 1'b0; b.sda = 1'b1; seq_hold(b, 3'd1);
			end
			PH_WA_B: begin
				b.scl = 1'b1; seq_hold(b, 3'd1);
			end
			PH_WR_BIT: begin
				b.sda_en = 1'b1; b.scl = 1'b0;
				b.sda = b.shreg[7];
				b.shreg = {b.shreg[6:0], 1'b0};
				seq_hold(b, 3'd2);
			end
			PH_WR_HI: begin
				b.scl = 1'b1; seq_hold(b, 3'd2);
			end
			PH_WR_LO: begin
				b.scl = 1'b0; seq_hold(b, 3'd2);
			end
			PH_RD_LO: begin
				b.sda_en = 1'b0; b.scl = 1'b0; seq_hold(b, 3'd2);
			end
			PH_RD_HI: begin
				// sample the data bit on the first tick of SCL high
				b.scl = 1'b1;
				b.shreg = {b.shreg[6:0], sda_in};
				seq_hold(b, 3'd1);
			end
			PH_AK_A: begin
				b.scl = 1'b0; b.sda_en = 1'b1; b.sda = ~b.ack_low; seq_hold(b, 3'd2);
			end
			PH_AK_B: begin
				b.scl = 1'b1; seq_hold(b, 3'd2);
			end
			PH_AK_C: begin
				b.scl = 1'b0; seq_finish(b);
			end
			default: seq_finish(b);
		endcase
	endfunction

	// Delay of a step ran out: move to the next step
	function automatic void seq_advance(inout bus_state_t b);
		b.units = '0;
		b.ticks = '0;
		case (b.phase)
			PH_ST_A: b.phase = PH_ST_B;
			PH_ST_B: b.phase = PH_ST_C;
			PH_SP_A: b.phase = PH_SP_B;
			PH_SP_B: b.phase = PH_SP_C;
			PH_WA_A: b.phase = PH_WA_B;
			PH_WA_B: b.phase = PH_WA_POLL;
			PH_WR_BIT: b.phase = PH_WR_HI;
			PH_WR_HI: b.phase = PH_WR_LO;
			PH_WR_LO: begin
				b.bit_idx = b.bit_idx + 4'd1;
				if (b.bit_idx >= 4'd8) seq_finish(b);
				else b.phase = PH_WR_BIT;
			end
			PH_RD_LO: b.phase = PH_RD_HI;
			PH_RD_HI: begin
				b.bit_idx = b.bit_idx + 4'd1;
				if (b.bit_idx >= 4'd8) begin
					b.rx = b.shreg;
					b.phase = PH_AK_A;
				end else begin
					b.phase = PH_RD_LO;
				end
			end
			PH_AK_A: b.phase = PH_AK_B;
			PH_AK_B: b.phase = PH_AK_C;
			default: seq_finish(b);
		endcase
	endfunction

	// Advance the sequencer by one tick and return the pin state after it
	function automatic res_t predict_pins(inout bus_state_t b, input logic [15:0] tpu,
			input logic [7:0] ato, input tick_t t);
		logic [16:0] unit_len;
		res_t r;
		unit_len = (tpu == 16'd0) ? 17'd1 : {1'b0, tpu};
		b.done = 1'b0;
		if (b.phase == PH_IDLE && t.op >= OP_START && t.op <= OP_WACK) begin
			b.cmd = t.op;
			b.units = '0;
			b.ticks = '0;
			b.bit_idx = '0;
			case (t.op)
				OP_START: b.phase = PH_ST_A;
				OP_STOP: b.phase = PH_SP_A;
				OP_WRITE: begin
					b.phase = PH_WR_BIT; b.shreg = t.tx;
				end
				OP_READ: begin
					b.phase = PH_RD_LO; b.shreg = '0; b.ack_low = t.ack;
				end
				default: begin
					b.phase = PH_WA_A; b.polls = '0; b.err = 1'b0;
				end
			endcase
		end
		if (b.phase == PH_WA_POLL) begin
			// one SDA sample per tick; low means acknowledged
			if (!t.sda) begin
				b.scl = 1'b0;
				seq_finish(b);
			end else if (b.polls >= ato) begin
				b.err = 1'b1;
				b.phase = PH_SP_A;
				b.units = '0;
				b.ticks = '0;
			end else begin
				b.polls = b.polls + 8'd1;
			end
		end else if (b.phase != PH_IDLE) begin
			if (b.units == 3'd0) seq_enter(b, t.sda);
			if (b.phase != PH_IDLE && b.units != 3'd0) begin
				b.ticks = b.ticks + 17'd1;
				if (b.ticks >= unit_len) begin
					b.ticks = '0;
					b.units = b.units - 3'd1;
					if (b.units == 3'd0) seq_advance(b);
				end
			end
		end
		r.scl_level = b.scl;
		r.sda_drive = b.sda;
		r.sda_enable = b.sda_en;
		r.busy_res = (b.phase != PH_IDLE);
		r.done_res = b.done;
		r.rx_byte = b.rx;
		r.ack_error = b.err;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------------
	// Stimulus generation
	// ---------------------------------------------------------------------------------------
	function automatic logic sda_pick(input int mode);
		case (mode)
			SDA_LOW: return 1'b0;
			SDA_HIGH: return 1'b1;
			SDA_SPARSE_LOW: return ($urandom_range(5) != 0);
			default: return 1'($urandom);
		endcase
	endfunction

	// Queue one tick beat and step the look-ahead copy with it
	task automatic add_tick(input logic [2:0] op, input logic [7:0] tx, input logic ack,
			input logic sda, input bit drain);
		tick_t t;
		t.op = op;
		t.tx = tx;
		t.ack = ack;
		t.sda = sda;
		t.drain = drain;
		tick_q.push_back(t);
		void'(predict_pins(lookahead_bus, tpu_reg, ato_reg, t));
		gen_ticks++;
	endtask

	// Issue a command, then keep ticking until the sequence is over.
	// noise_pct of the busy ticks carry a stray command that must be dropped.
	task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
			input int mode, input bit drain, input int noise_pct);
		logic [2:0] stray;
		add_tick(op, tx, ack, sda_pick(mode), drain);
		while (lookahead_bus.phase != PH_IDLE) begin
			stray = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(1, 7)) : OP_NONE;
			add_tick(stray, 8'($urandom), 1'($urandom), sda_pick(mode), 1'b0);
		end
	endtask

	// Mostly complete commands with random content, a few ignored opcodes in idle gaps
	task automatic random_traffic(input int n, input int noise_pct);
		int stop_at;
		int mode;
		logic [2:0] op;
		stop_at = gen_ticks + n;
		while (gen_ticks < stop_at) begin
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(2))
					0: op = OP_NONE;
					1: op = OP_SPARE6;
					default: op = OP_SPARE7;
				endcase
				add_tick(op, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
			end else begin
				op = 3'($urandom_range(OP_START, OP_WACK));
				if (op == OP_WACK) mode = ($urandom_range(3) == 0) ? SDA_HIGH : SDA_SPARSE_LOW;
				else mode = SDA_RANDOM;
				run_cmd(op, 8'($urandom), 1'($urandom), mode, $urandom_range(49) == 0,
					noise_pct);
			end
		end
	endtask

	// Wait until every queued beat went in and every result came back
	task automatic settle();
		while (tick_q.size() != 0 || s_tvalid || ticks_in != results_out) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_TICKS_PER_UNIT) tpu_reg = data;
		else if (idx == REG_ACK_TIMEOUT) ato_reg = data[7:0];
	endtask

	// Set the idling of both sides away from the clock edge
	task automatic begin_phase(input int src_pct, input int sink_pct);
		@(negedge clk);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	initial begin
		lookahead_bus = bus_reset();
		shadow_bus = bus_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset timing: ignored opcodes, then an acknowledged wait on the 200-tick unit
		begin_phase(10, 10);
		add_tick(OP_NONE, 8'hFF, 1'b1, 1'b1, 1'b0);
		add_tick(OP_SPARE6, 8'h00, 1'b0, 1'b0, 1'b0);
		add_tick(OP_SPARE7, 8'h81, 1'b1, 1'b0, 1'b0);
		run_cmd(OP_WACK, 8'h00, 1'b0, SDA_LOW, 1'b0, 0);
		settle();

		// Fastest timing with the reset ack window: run into the 250-sample limit
		cfg_write(REG_TICKS_PER_UNIT, 16'd1);
		begin_phase(15, 15);
		run_cmd(OP_WACK, 8'h00, 1'b0, SDA_HIGH, 1'b0, 0);
		settle();

		// Ack window of 1: each command at least once, then random traffic
		cfg_write(REG_ACK_TIMEOUT, {8'($urandom), 8'd1});
		begin_phase(15, 15);
		run_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0, 0);
		run_cmd(OP_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 1'b0, 0);
		run_cmd(OP_WRITE, 8'h00, 1'b1, SDA_RANDOM, 1'b0, 0);
		run_cmd(OP_WRITE, 8'hA5, 1'b1, SDA_RANDOM, 1'b0, 30);
		run_cmd(OP_READ, 8'h5A, 1'b1, SDA_HIGH, 1'b0, 0);
		run_cmd(OP_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0, 0);
		run_cmd(OP_READ, 8'($urandom), 1'b1, SDA_RANDOM, 1'b0, 0);
		run_cmd(OP_WACK, 8'h00, 1'b0, SDA_LOW, 1'b0, 0);
		run_cmd(OP_WACK, 8'h00, 1'b0, SDA_HIGH, 1'b0, 0);
		run_cmd(OP_WACK, 8'h00, 1'b0, SDA_SPARSE_LOW, 1'b0, 0);
		// hold the stop beat until the bus is quiet
		run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1, 0);
		run_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0, 100);
		random_traffic(100, 5);
		settle();

		// Zero length unit acts as one; zero ack window fails on the first high sample
		cfg_write(REG_TICKS_PER_UNIT, 16'd0);
		cfg_write(REG_ACK_TIMEOUT, {8'($urandom), 8'd0});
		begin_phase(0, 0);
		run_cmd(OP_WACK, 8'h00, 1'b0, SDA_HIGH, 1'b0, 0);
		run_cmd(OP_WRITE, 8'h3C, 1'b0, SDA_RANDOM, 1'b0, 0);
		random_traffic(80, 5);
		settle();

		cfg_write(REG_TICKS_PER_UNIT, 16'd2);
		cfg_write(REG_ACK_TIMEOUT, {8'($urandom), 8'd5});
		begin_phase(30, 10);
		random_traffic(80, 10);
		settle();

		// Widest ack window
		cfg_write(REG_TICKS_PER_UNIT, 16'd3);
		cfg_write(REG_ACK_TIMEOUT, {8'($urandom), 8'd255});
		begin_phase(10, 30);
		random_traffic(40, 5);
		settle();

		// Unused indexes must leave both registers alone; then a longer unit
		cfg_write(2'd2, 16'($urandom));
		cfg_write(2'd3, 16'($urandom));
		cfg_write(REG_TICKS_PER_UNIT, 16'd37);
		cfg_write(REG_ACK_TIMEOUT, 16'($urandom_range(1, 255)));
		begin_phase(3, 3);
		run_cmd(OP_WACK, 8'h00, 1'b0, SDA_LOW, 1'b0, 1);
		settle();

		// Closing stretch at full rate on both sides
		cfg_write(REG_TICKS_PER_UNIT, 16'd1);
		cfg_write(REG_ACK_TIMEOUT, 16'($urandom_range(1, 4)));
		begin_phase(0, 0);
		random_traffic(80, 5);
		settle();

		repeat (8) @(posedge clk);
		if (pin_results_q.size() != 0) begin
			errors++;
			$display("%0t: %0d predicted results never arrived", $time, pin_results_q.size());
		end
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------------------------------
	// Tick driver: predict on each accepted beat, then present the next one
	// ---------------------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : tick_drive
		tick_t nxt;
		tick_t seen;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				// rebuild the tick from the bus so packing errors show up as mismatches
				seen.op = s_tuser;
				seen.tx = s_tdata[7:0];
				seen.ack = s_tdata[8];
				seen.sda = s_tdata[9];
				seen.drain = 1'b0;
				pin_results_q.push_back(predict_pins(shadow_bus, tpu_reg, ato_reg, seen));
				ticks_in <= ticks_in + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					s_tvalid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (tick_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (tick_q[0].drain && (s_tvalid || ticks_in != results_out)) begin
					// drop valid and wait for the result side to catch up
					s_tvalid <= 1'b0;
				end else if ($urandom_range(99) < src_idle_pct) begin
					s_tvalid <= 1'b0;
					src_gap <= $urandom_range(0, 13);
				end else begin
					nxt = tick_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, nxt.sda, nxt.ack, nxt.tx};
					s_tuser <= nxt.op;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Result monitor: compare each accepted beat against the oldest prediction
	// ---------------------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_check
		res_t got;
		res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_out <= results_out + 1;
				got = m_tdata[13:0];
				if (pin_results_q.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing predicted, expected none, actual %h",
						$time, m_tdata);
				end else begin
					want = pin_results_q.pop_front();
					check_field("scl_level", want.scl_level, got.scl_level);
					check_field("sda_drive", want.sda_drive, got.sda_drive);
					check_field("sda_enable", want.sda_enable, got.sda_enable);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("done_res", want.done_res, got.done_res);
					check_field("rx_byte", want.rx_byte, got.rx_byte);
					check_field("ack_error", want.ack_error, got.ack_error);
				end
			end
			// stall the result side in bursts
			if (sink_gap != 0) begin
				m_tready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else if ($urandom_range(99) < sink_idle_pct) begin
				m_tready <= 1'b0;
				sink_gap <= $urandom_range(0, 13);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Hang detection: any accepted beat on any channel restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_seq.sv
rtl/i2c_master_bit_engine.sv
tb/tb_i2c_master_bit_engine.sv
